@@ rtl/heading_to_unit_vector_defines.svh @@
// Assertion helpers shared by heading_to_unit_vector.sv and h2uv_angle.sv.
`ifndef HEADING_TO_UNIT_VECTOR_DEFINES_SVH
`define HEADING_TO_UNIT_VECTOR_DEFINES_SVH

`ifndef SYNTH
`define H2UV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define H2UV_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define H2UV_ASSERT(label, prop, msg)
`define H2UV_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ rtl/h2uv_pkg.sv @@
`default_nettype none

package h2uv_pkg;

    localparam int HEADING_W     = 20;
    localparam int OUT_W         = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int WORK_FRAC     = 30;

    // datapath widths: Q2.30 values and binary angles with headroom
    localparam int CW = 34;
    localparam int ZW = 34;

    localparam longint GAIN_Q30 = 652032874;

    // heading reduction: one turn is 92160 = 45 * 2048 units
    localparam int DEG_180    = 46080;
    localparam int U_BIAS     = 315;
    localparam int RECIP45    = 1456;
    localparam int DIV45      = 45;
    // 2^32 = 45 * A_STEP + A_REM, 2^21 = 45 * B_STEP + B_REM
    localparam int unsigned A_STEP = 95443717;
    localparam int A_REM      = 31;
    localparam int B_STEP     = 46603;
    localparam int B_REM      = 17;
    localparam int ROUND_BIAS = 22;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sh4000_0000);

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_NORTH_ON_X = '0;

    typedef struct packed {
        logic                 valid;
        logic                 negate;
        logic signed [ZW-1:0] z;
    } angle_t;

    typedef struct packed {
        logic                 valid;
        logic                 negate;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } rot_t;

    function automatic logic signed [ZW-1:0] atan_bam(input logic [4:0] idx);
        logic signed [ZW-1:0] a;
        unique case (idx)
            5'd0:    a = ZW'(64'sh2000_0000);
            5'd1:    a = ZW'(64'sh12E4_051E);
            5'd2:    a = ZW'(64'sh09FB_385B);
            5'd3:    a = ZW'(64'sh0511_11D4);
            5'd4:    a = ZW'(64'sh028B_0D43);
            5'd5:    a = ZW'(64'sh0145_D7E1);
            5'd6:    a = ZW'(64'sh00A2_F61E);
            5'd7:    a = ZW'(64'sh0051_7C55);
            5'd8:    a = ZW'(64'sh0028_BE53);
            5'd9:    a = ZW'(64'sh0014_5F2F);
            5'd10:   a = ZW'(64'sh000A_2F98);
            5'd11:   a = ZW'(64'sh0005_17CC);
            5'd12:   a = ZW'(64'sh0002_8BE6);
            5'd13:   a = ZW'(64'sh0001_45F3);
            5'd14:   a = ZW'(64'sh0000_A2FA);
            5'd15:   a = ZW'(64'sh0000_517D);
            5'd16:   a = ZW'(64'sh0000_28BE);
            5'd17:   a = ZW'(64'sh0000_145F);
            5'd18:   a = ZW'(64'sh0000_0A30);
            5'd19:   a = ZW'(64'sh0000_0518);
            5'd20:   a = ZW'(64'sh0000_028C);
            5'd21:   a = ZW'(64'sh0000_0146);
            5'd22:   a = ZW'(64'sh0000_00A3);
            5'd23:   a = ZW'(64'sh0000_0051);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ rtl/heading_to_unit_vector.sv @@
// Pipeline from an accepted item to dir_valid: five angle reduction stages, one register
// per CORDIC iteration, a select stage, a rounding stage and the output register.
// Throughput: one item per cycle while heading_stall is low; a two-entry output register
// and skid stage absorb stalls.
// Reset (rst_n low, asynchronous): all pipeline valid bits clear and north_on_x_axis
// returns to 0, so north lies on the y axis.
`default_nettype none

module heading_to_unit_vector (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  heading_valid,
    output logic                                       heading_stall,
    input  wire logic signed [h2uv_pkg::HEADING_W-1:0] heading,
    output logic                                       dir_valid,
    input  wire logic                                  dir_stall,
    output logic signed [h2uv_pkg::OUT_W-1:0]          dir_x,
    output logic signed [h2uv_pkg::OUT_W-1:0]          dir_y,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [h2uv_pkg::ADDR_W-1:0]           paddr,
    input  wire logic [h2uv_pkg::DATA_W-1:0]           pwdata,
    output logic [h2uv_pkg::DATA_W-1:0]                prdata,
    output logic                                       pready
);
    import h2uv_pkg::*;

    `include "heading_to_unit_vector_defines.svh"

    localparam int SH = WORK_FRAC - OUT_FRAC_BITS;
    localparam logic signed [CW:0] RND    = (CW+1)'((1 << SH) >> 1);
    localparam logic signed [CW:0] SAT_HI = (CW+1)'(2 ** (OUT_W - 1) - 1);
    localparam logic signed [CW:0] SAT_LO = -SAT_HI - (CW+1)'(1);

    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [CW-1:0] v);
        logic signed [CW:0] r;
        r = ($signed({v[CW-1], v}) + RND) >>> SH;
        if (r > SAT_HI)
        begin
            return SAT_HI[OUT_W-1:0];
        end
        else if (r < SAT_LO)
        begin
            return SAT_LO[OUT_W-1:0];
        end
        return r[OUT_W-1:0];
    endfunction

    logic north_on_x_axis_reg;
    logic en;

    angle_t ang;
    rot_t   rot;

    logic                 sel_valid_reg;
    logic signed [CW-1:0] sel_x_reg;
    logic signed [CW-1:0] sel_y_reg;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] sel_x_next;
    logic signed [CW-1:0] sel_y_next;

    logic                    fin_valid_reg;
    logic signed [OUT_W-1:0] fin_x_reg;
    logic signed [OUT_W-1:0] fin_y_reg;

    logic                    dir_valid_reg;
    logic signed [OUT_W-1:0] dir_x_reg;
    logic signed [OUT_W-1:0] dir_y_reg;
    logic                    skid_valid_reg;
    logic signed [OUT_W-1:0] skid_x_reg;
    logic signed [OUT_W-1:0] skid_y_reg;

    logic take;
    logic load_out;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            north_on_x_axis_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[ADDR_W-1:2] == REG_NORTH_ON_X)
        begin
            north_on_x_axis_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[ADDR_W-1:2] == REG_NORTH_ON_X)
        begin
            prdata[0] = north_on_x_axis_reg;
        end
    end

    // advance the angle, CORDIC, select and rounding stages unless the skid stage holds an item
    assign en            = !skid_valid_reg;
    assign heading_stall = skid_valid_reg;

    h2uv_angle u_angle (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid   (heading_valid),
        .heading (heading),
        .ang     (ang)
    );

    h2uv_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ang   (ang),
        .rot   (rot)
    );

    always_comb
    begin
        c = rot.negate ? -rot.x : rot.x;
        s = rot.negate ? -rot.y : rot.y;
        if (north_on_x_axis_reg)
        begin
            sel_x_next = c;
            sel_y_next = s;
        end
        else
        begin
            sel_x_next = -s;
            sel_y_next = c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sel_valid_reg <= rot.valid;
            fin_valid_reg <= sel_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_x_reg <= sel_x_next;
            sel_y_reg <= sel_y_next;
            fin_x_reg <= round_sat(sel_x_reg);
            fin_y_reg <= round_sat(sel_y_reg);
        end
    end

    // output register with skid stage
    assign take     = en && fin_valid_reg;
    assign load_out = !dir_valid_reg || !dir_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            if (skid_valid_reg)
            begin
                dir_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                dir_valid_reg <= take;
            end
        end
        else if (take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            dir_x_reg <= skid_valid_reg ? skid_x_reg : fin_x_reg;
            dir_y_reg <= skid_valid_reg ? skid_y_reg : fin_y_reg;
        end
        else if (take)
        begin
            skid_x_reg <= fin_x_reg;
            skid_y_reg <= fin_y_reg;
        end
    end

    assign dir_valid = dir_valid_reg;
    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;

    `H2UV_ASSERT(a_skid_needs_out, skid_valid_reg |-> dir_valid_reg, "skid without output")
    `H2UV_ASSERT(a_skid_fill_on_stall, $rose(skid_valid_reg) |-> $past(dir_valid_reg && dir_stall), "skid fill")
    `H2UV_ASSERT(a_skid_drain, (dir_valid_reg && !dir_stall && skid_valid_reg) |=> (dir_valid_reg && !skid_valid_reg), "skid drain")

endmodule

`default_nettype wire

@@ rtl/h2uv_angle.sv @@
`default_nettype none

module h2uv_angle (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  wire logic                                  valid,
    input  wire logic signed [h2uv_pkg::HEADING_W-1:0] heading,
    output h2uv_pkg::angle_t                           ang
);
    import h2uv_pkg::*;

    `include "heading_to_unit_vector_defines.svh"

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic [9:0]  u1_reg;
    logic [10:0] b1_reg;
    logic [5:0]  a2_reg;
    logic [10:0] b2_reg;
    logic [31:0] pa3_reg;
    logic [26:0] pb3_reg;
    logic [15:0] w3_reg;
    logic [31:0] s4_reg;
    logic [9:0]  qg4_reg;
    logic [15:0] w4_reg;
    logic signed [ZW-1:0] z5_reg;
    logic        n5_reg;

    logic signed [HEADING_W:0] shifted;
    logic [9:0]  u1_next;
    logic [19:0] qprod1;
    logic [3:0]  q1;
    logic [9:0]  rem1;
    logic [5:0]  a2_next;
    logic [25:0] qprod2;
    logic [15:0] rem2;
    logic [9:0]  qf;
    logic [31:0] bam;
    logic        fold;

    always_comb
    begin
        // theta = heading - 180 degrees, split into 2048-unit blocks and an offset
        shifted = $signed({heading[HEADING_W-1], heading}) - (HEADING_W+1)'(DEG_180);
        u1_next = 10'(shifted[HEADING_W:11]) + 10'(U_BIAS);

        // block index modulo 45
        qprod1  = 20'(u1_reg) * 20'(RECIP45);
        q1      = qprod1[19:16];
        rem1    = u1_reg - 10'(q1) * 10'(DIV45);
        a2_next = (rem1 >= 10'(DIV45)) ? 6'(rem1 - 10'(DIV45)) : 6'(rem1);

        qprod2  = 26'(w3_reg) * 26'(RECIP45);

        // binary angle, then fold the left half plane by half a turn
        rem2 = w4_reg - 16'(qg4_reg) * 16'(DIV45);
        qf   = qg4_reg + 10'(rem2 >= 16'(DIV45));
        bam  = s4_reg + 32'(qf);
        fold = bam[31] ^ bam[30];
        if (fold)
        begin
            bam[31] = ~bam[31];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u1_reg  <= u1_next;
            b1_reg  <= shifted[10:0];
            a2_reg  <= a2_next;
            b2_reg  <= b1_reg;
            pa3_reg <= 32'(a2_reg) * A_STEP;
            pb3_reg <= 27'(b2_reg) * 27'(B_STEP);
            w3_reg  <= 16'(a2_reg) * 16'(A_REM) + 16'(b2_reg) * 16'(B_REM)
                       + 16'(ROUND_BIAS);
            s4_reg  <= pa3_reg + 32'(pb3_reg);
            qg4_reg <= qprod2[25:16];
            w4_reg  <= w3_reg;
            z5_reg  <= ZW'($signed(bam));
            n5_reg  <= fold;
        end
    end

    assign ang.valid  = v5_reg;
    assign ang.negate = n5_reg;
    assign ang.z      = z5_reg;

    `H2UV_ASSERT(a_folded_range, v5_reg |-> (z5_reg <= QUARTER_TURN && z5_reg >= -QUARTER_TURN), "folded angle outside a quarter turn")

endmodule

`default_nettype wire

@@ rtl/h2uv_cordic.sv @@
`default_nettype none

module h2uv_cordic (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire h2uv_pkg::angle_t ang,
    output h2uv_pkg::rot_t        rot
);
    import h2uv_pkg::*;

    logic [CORDIC_STAGES-1:0] v_reg;
    logic [CORDIC_STAGES-1:0] n_reg;
    logic signed [CW-1:0] x_reg [CORDIC_STAGES];
    logic signed [CW-1:0] y_reg [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg [CORDIC_STAGES-1];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic                 v_in;
        logic                 n_in;
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic signed [CW-1:0] x_sh;
        logic signed [CW-1:0] y_sh;

        if (i == 0)
        begin : g_first
            assign v_in = ang.valid;
            assign n_in = ang.negate;
            assign x_in = CW'(GAIN_Q30);
            assign y_in = '0;
            assign z_in = ang.z;
        end
        else
        begin : g_next
            assign v_in = v_reg[i-1];
            assign n_in = n_reg[i-1];
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        assign x_sh = x_in >>> i;
        assign y_sh = y_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i] <= n_in;
                if (!z_in[ZW-1])
                begin
                    x_reg[i] <= x_in - y_sh;
                    y_reg[i] <= y_in + x_sh;
                end
                else
                begin
                    x_reg[i] <= x_in + y_sh;
                    y_reg[i] <= y_in - x_sh;
                end
            end
        end

        if (i < CORDIC_STAGES - 1)
        begin : g_z
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!z_in[ZW-1])
                    begin
                        z_reg[i] <= z_in - atan_bam(5'(i));
                    end
                    else
                    begin
                        z_reg[i] <= z_in + atan_bam(5'(i));
                    end
                end
            end
        end
    end

    assign rot.valid  = v_reg[CORDIC_STAGES-1];
    assign rot.negate = n_reg[CORDIC_STAGES-1];
    assign rot.x      = x_reg[CORDIC_STAGES-1];
    assign rot.y      = y_reg[CORDIC_STAGES-1];

endmodule

`default_nettype wire
